/* sv/conv2d_forward_accumulate_defines.svh */
// assertion macros shared by the checker
// no dependencies
`ifndef CONV2D_FORWARD_ACCUMULATE_DEFINES_SVH
`define CONV2D_FORWARD_ACCUMULATE_DEFINES_SVH
// implication checked on every clock edge outside reset
`define C2D_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// implication checked in the cycle after the antecedent
`define C2D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* sv/c2d_pkg.sv */
// shared types and constants for the convolution block
// no dependencies
package c2d_pkg;
    localparam int MaxInCh = 16;
    localparam int MaxOutCh = 16;
    localparam int MaxInDim = 32;
    localparam int MaxOutDim = 32;
    localparam int MaxKernel = 4;

    localparam logic [2:0] FUNC_LOAD_ACT = 3'd0;
    localparam logic [2:0] FUNC_LOAD_WGT = 3'd1;
    localparam logic [2:0] FUNC_LOAD_OUT = 3'd2;
    localparam logic [2:0] FUNC_COMPUTE = 3'd3;
    localparam logic [2:0] FUNC_READ = 3'd4;

    localparam logic [2:0] REG_IN_CH = 3'd0;
    localparam logic [2:0] REG_OUT_CH = 3'd1;
    localparam logic [2:0] REG_OUT_ROWS = 3'd2;
    localparam logic [2:0] REG_OUT_COLS = 3'd3;
    localparam logic [2:0] REG_KER_ROWS = 3'd4;
    localparam logic [2:0] REG_KER_COLS = 3'd5;
    localparam logic [2:0] REG_STR_ROWS = 3'd6;
    localparam logic [2:0] REG_STR_COLS = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_OUT_RD,
        ST_OUT_WAIT,
        ST_MAC_ISSUE,
        ST_MAC_DRAIN,
        ST_WRITE,
        ST_RESULT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic acc_load;   // load accumulator from output memory data
        logic mac_issue;  // present addresses for one tap
        logic writeback;  // write saturated sum
        logic out_rd;     // read output memory at current position
        logic err_clear;
        logic res_load;   // capture result beat
        logic res_is_read;
        logic res_is_comp;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic tap_last;   // last tap of the current output
        logic pos_last;   // last output position
        logic pos_empty;  // no output position at all
        logic tap_empty;  // no taps at all
        logic pipe_busy;  // mac pipeline holds taps
    } t_stat;
endpackage

/* sv/c2d_ram.sv */
// generic single-port-write ram with registered read
// no dependencies
module c2d_ram #(
    parameter int Width = 16,
    parameter int Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

/* sv/c2d_ctrl.sv */
// controller state machine for the convolution block
// depends on c2d_pkg
module c2d_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [2:0]    i_func,
    input  logic          i_res_full,
    input  logic          i_res_take,
    input  c2d_pkg::t_stat i_stat,
    output c2d_pkg::t_cmd  o_cmd,
    output logic          o_ready
);
    c2d_pkg::t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= c2d_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_ready = 1'b0;
        unique case (r_state)
            c2d_pkg::ST_IDLE: begin
                // loads stream; a beat waits only for a free result slot
                o_ready = !i_res_full || i_res_take;
                if (i_valid && o_ready) begin
                    if (i_func == c2d_pkg::FUNC_COMPUTE) begin
                        o_cmd.err_clear = 1'b1;
                        n_state = c2d_pkg::ST_OUT_RD;
                    end else if (i_func == c2d_pkg::FUNC_READ) begin
                        n_state = c2d_pkg::ST_READ;
                    end else begin
                        o_cmd.res_load = 1'b1;
                    end
                end
            end
            c2d_pkg::ST_READ: begin
                // memory data arrives this cycle
                o_cmd.res_load = 1'b1;
                o_cmd.res_is_read = 1'b1;
                n_state = c2d_pkg::ST_IDLE;
            end
            c2d_pkg::ST_OUT_RD: begin
                if (i_stat.pos_empty) begin
                    n_state = c2d_pkg::ST_RESULT;
                end else begin
                    o_cmd.out_rd = 1'b1;
                    n_state = c2d_pkg::ST_OUT_WAIT;
                end
            end
            c2d_pkg::ST_OUT_WAIT: begin
                o_cmd.acc_load = 1'b1;
                n_state = i_stat.tap_empty ? c2d_pkg::ST_MAC_DRAIN : c2d_pkg::ST_MAC_ISSUE;
            end
            c2d_pkg::ST_MAC_ISSUE: begin
                o_cmd.mac_issue = 1'b1;
                if (i_stat.tap_last) begin
                    n_state = c2d_pkg::ST_MAC_DRAIN;
                end
            end
            c2d_pkg::ST_MAC_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_state = c2d_pkg::ST_WRITE;
                end
            end
            c2d_pkg::ST_WRITE: begin
                o_cmd.writeback = 1'b1;
                n_state = i_stat.pos_last ? c2d_pkg::ST_RESULT : c2d_pkg::ST_OUT_RD;
            end
            c2d_pkg::ST_RESULT: begin
                if (!i_res_full || i_res_take) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_is_comp = 1'b1;
                    n_state = c2d_pkg::ST_IDLE;
                end
            end
            default: n_state = c2d_pkg::ST_IDLE;
        endcase
    end
endmodule

/* sv/c2d_dp.sv */
// datapath: stores, loop counters, multiply-accumulate and result register
// depends on c2d_pkg and c2d_ram
module c2d_dp #(
    parameter int MaxInCh = c2d_pkg::MaxInCh,
    parameter int MaxOutCh = c2d_pkg::MaxOutCh,
    parameter int MaxInDim = c2d_pkg::MaxInDim,
    parameter int MaxOutDim = c2d_pkg::MaxOutDim,
    parameter int MaxKernel = c2d_pkg::MaxKernel
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_beat,
    input  logic [2:0]           i_func,
    input  logic [3:0]           i_out_chan,
    input  logic [3:0]           i_in_chan,
    input  logic [4:0]           i_row_index,
    input  logic [4:0]           i_col_index,
    input  logic signed [15:0]   i_sample,
    input  logic signed [31:0]   i_acc_value,
    input  logic                 i_cfg_beat,
    input  logic [2:0]           i_cfg_index,
    input  logic [5:0]           i_cfg_data,
    input  c2d_pkg::t_cmd        i_cmd,
    input  logic                 i_res_take,
    output c2d_pkg::t_stat       o_stat,
    output logic                 o_res_full,
    output logic signed [31:0]   o_read_value,
    output logic                 o_range_error
);
    localparam int IcW = (MaxInCh > 1) ? $clog2(MaxInCh) : 1;
    localparam int OcW = (MaxOutCh > 1) ? $clog2(MaxOutCh) : 1;
    localparam int IdW = (MaxInDim > 1) ? $clog2(MaxInDim) : 1;
    localparam int OdW = (MaxOutDim > 1) ? $clog2(MaxOutDim) : 1;
    localparam int KW = (MaxKernel > 1) ? $clog2(MaxKernel) : 1;
    localparam int ActDepth = MaxInCh * MaxInDim * MaxInDim;
    localparam int WgtDepth = MaxOutCh * MaxInCh * MaxKernel * MaxKernel;
    localparam int OutDepth = MaxOutCh * MaxOutDim * MaxOutDim;
    localparam int AaW = $clog2(ActDepth);
    localparam int WaW = $clog2(WgtDepth);
    localparam int OaW = $clog2(OutDepth);
    // window coordinate: y*stride+ky stays below 2^(OdW+5)
    localparam int WinW = OdW + 5;

    // configuration registers
    logic [4:0] r_nic, r_noc;
    logic [5:0] r_nrow, r_ncol;
    logic [2:0] r_kr, r_kc, r_sr, r_sc;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nic <= 5'd1; r_noc <= 5'd1; r_nrow <= 6'd1; r_ncol <= 6'd1;
            r_kr <= 3'd1; r_kc <= 3'd1; r_sr <= 3'd1; r_sc <= 3'd1;
        end else if (i_cfg_beat) begin
            unique case (i_cfg_index)
                c2d_pkg::REG_IN_CH:    r_nic <= i_cfg_data[4:0];
                c2d_pkg::REG_OUT_CH:   r_noc <= i_cfg_data[4:0];
                c2d_pkg::REG_OUT_ROWS: r_nrow <= i_cfg_data;
                c2d_pkg::REG_OUT_COLS: r_ncol <= i_cfg_data;
                c2d_pkg::REG_KER_ROWS: r_kr <= i_cfg_data[2:0];
                c2d_pkg::REG_KER_COLS: r_kc <= i_cfg_data[2:0];
                c2d_pkg::REG_STR_ROWS: r_sr <= i_cfg_data[2:0];
                c2d_pkg::REG_STR_COLS: r_sc <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // clamped loop bounds (counts as 32-bit ints)
    int nic, noc, nrow, ncol, nkr, nkc;
    always_comb begin
        nic = (int'(r_nic) > MaxInCh) ? MaxInCh : int'(r_nic);
        noc = (int'(r_noc) > MaxOutCh) ? MaxOutCh : int'(r_noc);
        nrow = (int'(r_nrow) > MaxOutDim) ? MaxOutDim : int'(r_nrow);
        ncol = (int'(r_ncol) > MaxOutDim) ? MaxOutDim : int'(r_ncol);
        nkr = (int'(r_kr) > MaxKernel) ? MaxKernel : int'(r_kr);
        nkc = (int'(r_kc) > MaxKernel) ? MaxKernel : int'(r_kc);
    end

    // output position counters
    logic [OcW-1:0] r_po;
    logic [OdW-1:0] r_py, r_px;
    // tap counters
    logic [IcW-1:0] r_tc;
    logic [KW-1:0]  r_tky, r_tkx;

    logic px_last, py_last, po_last, kx_last, ky_last, tc_last;
    assign px_last = int'(r_px) == ncol - 1;
    assign py_last = int'(r_py) == nrow - 1;
    assign po_last = int'(r_po) == noc - 1;
    assign kx_last = int'(r_tkx) == nkc - 1;
    assign ky_last = int'(r_tky) == nkr - 1;
    assign tc_last = int'(r_tc) == nic - 1;

    assign o_stat.tap_last = kx_last && ky_last && tc_last;
    assign o_stat.pos_last = px_last && py_last && po_last;
    assign o_stat.pos_empty = (noc == 0) || (nrow == 0) || (ncol == 0);
    assign o_stat.tap_empty = (nic == 0) || (nkr == 0) || (nkc == 0);

    // loop walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.err_clear) begin
            r_po <= '0; r_py <= '0; r_px <= '0;
            r_tc <= '0; r_tky <= '0; r_tkx <= '0;
        end else begin
            if (i_cmd.mac_issue) begin
                if (kx_last) begin
                    r_tkx <= '0;
                    if (ky_last) begin
                        r_tky <= '0;
                        r_tc <= tc_last ? '0 : r_tc + 1'b1;
                    end else begin
                        r_tky <= r_tky + 1'b1;
                    end
                end else begin
                    r_tkx <= r_tkx + 1'b1;
                end
            end
            if (i_cmd.writeback) begin
                if (px_last) begin
                    r_px <= '0;
                    if (py_last) begin
                        r_py <= '0;
                        r_po <= po_last ? '0 : r_po + 1'b1;
                    end else begin
                        r_py <= r_py + 1'b1;
                    end
                end else begin
                    r_px <= r_px + 1'b1;
                end
            end
        end
    end

    // window coordinates of the current tap
    logic [WinW-1:0] win_r, win_c;
    logic            win_out;
    assign win_r = WinW'(r_py * r_sr) + WinW'(r_tky);
    assign win_c = WinW'(r_px * r_sc) + WinW'(r_tkx);
    assign win_out = (32'(win_r) >= 32'(MaxInDim)) || (32'(win_c) >= 32'(MaxInDim));

    // activation memory
    logic          act_we;
    logic [AaW-1:0] act_waddr, act_raddr;
    logic [15:0]   act_rdata;
    assign act_we = i_in_beat && (i_func == c2d_pkg::FUNC_LOAD_ACT)
        && (32'(i_in_chan) < 32'(MaxInCh)) && (32'(i_row_index) < 32'(MaxInDim))
        && (32'(i_col_index) < 32'(MaxInDim));
    assign act_waddr = AaW'((32'(i_in_chan) * MaxInDim + 32'(i_row_index)) * MaxInDim
        + 32'(i_col_index));
    assign act_raddr = AaW'((32'(r_tc) * MaxInDim + 32'(win_r)) * MaxInDim + 32'(win_c));
    c2d_ram #(.Width(16), .Depth(ActDepth)) u_act (
        .i_clk(i_clk), .i_we(act_we), .i_waddr(act_waddr), .i_wdata(i_sample),
        .i_raddr(act_raddr), .o_rdata(act_rdata)
    );

    // weight memory
    logic           wgt_we;
    logic [WaW-1:0] wgt_waddr, wgt_raddr;
    logic [15:0]    wgt_rdata;
    assign wgt_we = i_in_beat && (i_func == c2d_pkg::FUNC_LOAD_WGT)
        && (32'(i_out_chan) < 32'(MaxOutCh)) && (32'(i_in_chan) < 32'(MaxInCh))
        && (32'(i_row_index) < 32'(MaxKernel)) && (32'(i_col_index) < 32'(MaxKernel));
    assign wgt_waddr = WaW'(((32'(i_out_chan) * MaxInCh + 32'(i_in_chan)) * MaxKernel
        + 32'(i_row_index)) * MaxKernel + 32'(i_col_index));
    assign wgt_raddr = WaW'(((32'(r_po) * MaxInCh + 32'(r_tc)) * MaxKernel
        + 32'(r_tky)) * MaxKernel + 32'(r_tkx));
    c2d_ram #(.Width(16), .Depth(WgtDepth)) u_wgt (
        .i_clk(i_clk), .i_we(wgt_we), .i_waddr(wgt_waddr), .i_wdata(i_sample),
        .i_raddr(wgt_raddr), .o_rdata(wgt_rdata)
    );

    // output memory: host load or writeback; read at host or walk address
    logic           out_in_range, out_we;
    logic [OaW-1:0] out_host_addr, out_pos_addr, out_waddr, out_raddr;
    logic [31:0]    out_wdata, out_rdata;
    logic signed [31:0] sat_sum;
    assign out_in_range = (32'(i_out_chan) < 32'(MaxOutCh))
        && (32'(i_row_index) < 32'(MaxOutDim)) && (32'(i_col_index) < 32'(MaxOutDim));
    assign out_host_addr = OaW'((32'(i_out_chan) * MaxOutDim + 32'(i_row_index))
        * MaxOutDim + 32'(i_col_index));
    assign out_pos_addr = OaW'((32'(r_po) * MaxOutDim + 32'(r_py)) * MaxOutDim
        + 32'(r_px));
    assign out_we = i_cmd.writeback
        || (i_in_beat && (i_func == c2d_pkg::FUNC_LOAD_OUT) && out_in_range);
    assign out_waddr = i_cmd.writeback ? out_pos_addr : out_host_addr;
    assign out_wdata = i_cmd.writeback ? sat_sum : i_acc_value;
    assign out_raddr = i_cmd.out_rd ? out_pos_addr : out_host_addr;
    c2d_ram #(.Width(32), .Depth(OutDepth)) u_out (
        .i_clk(i_clk), .i_we(out_we), .i_waddr(out_waddr), .i_wdata(out_wdata),
        .i_raddr(out_raddr), .o_rdata(out_rdata)
    );

    // mac pipeline: issue -> data valid -> product -> accumulate
    logic        r_v1, r_v2, r_oob1;
    logic signed [31:0] r_prod;
    logic signed [47:0] r_acc;
    logic        r_err;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_err <= 1'b0;
        end else begin
            r_v1 <= i_cmd.mac_issue;
            r_v2 <= r_v1;
            if (i_cmd.err_clear) begin
                r_err <= 1'b0;
            end else if (i_cmd.mac_issue && win_out) begin
                r_err <= 1'b1;
            end
        end
        r_oob1 <= win_out;
        r_prod <= $signed(wgt_rdata) * (r_oob1 ? 16'sd0 : $signed(act_rdata));
        if (i_cmd.acc_load) begin
            r_acc <= 48'(signed'(out_rdata));
        end else if (r_v2) begin
            r_acc <= r_acc + 48'(r_prod);
        end
    end
    assign o_stat.pipe_busy = r_v1 || r_v2;

    // saturate to 32 bits
    always_comb begin
        if (r_acc > 48'sh0000_7FFF_FFFF) begin
            sat_sum = 32'sh7FFF_FFFF;
        end else if (r_acc < -48'sh0000_8000_0000) begin
            sat_sum = 32'sh8000_0000;
        end else begin
            sat_sum = r_acc[31:0];
        end
    end

    // result register, one beat
    logic        r_res_full, r_read_oob, r_res_err;
    logic [31:0] r_res_val;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_full <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_res_full <= 1'b1;
        end else if (i_res_take) begin
            r_res_full <= 1'b0;
        end
        if (i_in_beat) begin
            r_read_oob <= !out_in_range;
        end
        if (i_cmd.res_load) begin
            r_res_val <= (i_cmd.res_is_read && !r_read_oob) ? out_rdata : 32'd0;
            r_res_err <= i_cmd.res_is_comp && r_err;
        end
    end
    assign o_res_full = r_res_full;
    assign o_read_value = r_res_val;
    assign o_range_error = r_res_err;
endmodule

/* sv/conv2d_forward_accumulate.sv */
// top level of the convolution block: controller plus datapath
// depends on c2d_pkg, c2d_ctrl, c2d_dp, c2d_ram
//
// usage:
// - command channel i_valid/o_ready carries one beat per command (func and
//   addresses); result channel o_valid/i_ready returns exactly one beat each
// - config channel i_cfg_valid/o_cfg_ready writes register i_cfg_index;
//   always ready, write only while no command is in flight
// - loads: one per cycle while the result slot is free or being taken;
//   result in the cycle after the beat
// - read: the registered output memory read port feeds the result register
// - compute: one tap a cycle through the activation and weight memory ports
//   and the multiply-accumulate stage
// - a single result register parts the channels: a load is taken while a
//   result waits only if the receiver takes it in the same cycle
// - reset clears control and registers to 1; memories are not cleared
// - a stalled receiver holds the result and stops new commands
module conv2d_forward_accumulate #(
    parameter int MaxInCh = c2d_pkg::MaxInCh,
    parameter int MaxOutCh = c2d_pkg::MaxOutCh,
    parameter int MaxInDim = c2d_pkg::MaxInDim,
    parameter int MaxOutDim = c2d_pkg::MaxOutDim,
    parameter int MaxKernel = c2d_pkg::MaxKernel
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_func,
    input  logic [3:0]         i_out_chan,
    input  logic [3:0]         i_in_chan,
    input  logic [4:0]         i_row_index,
    input  logic [4:0]         i_col_index,
    input  logic signed [15:0] i_sample,
    input  logic signed [31:0] i_acc_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_read_value,
    output logic               o_done_res,
    output logic               o_range_error,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [5:0]         i_cfg_data
);
    c2d_pkg::t_cmd  cmd;
    c2d_pkg::t_stat stat;
    logic res_full, res_take, in_beat;

    assign res_take = res_full && i_ready;
    assign in_beat = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;
    assign o_valid = res_full;
    assign o_done_res = 1'b1;

    c2d_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_func(i_func),
        .i_res_full(res_full), .i_res_take(res_take), .i_stat(stat),
        .o_cmd(cmd), .o_ready(o_ready)
    );

    c2d_dp #(
        .MaxInCh(MaxInCh), .MaxOutCh(MaxOutCh), .MaxInDim(MaxInDim),
        .MaxOutDim(MaxOutDim), .MaxKernel(MaxKernel)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_beat(in_beat), .i_func(i_func),
        .i_out_chan(i_out_chan), .i_in_chan(i_in_chan), .i_row_index(i_row_index),
        .i_col_index(i_col_index), .i_sample(i_sample), .i_acc_value(i_acc_value),
        .i_cfg_beat(i_cfg_valid), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_cmd(cmd), .i_res_take(res_take), .o_stat(stat), .o_res_full(res_full),
        .o_read_value(o_read_value), .o_range_error(o_range_error)
    );
endmodule

/* sv/c2d_checker.sv */
// port-level checker for the convolution block, bound to the top level
// depends on conv2d_forward_accumulate_defines.svh and c2d_pkg
`include "conv2d_forward_accumulate_defines.svh"
module c2d_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [2:0]  i_func,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_read_value,
    input logic        o_range_error
);
    logic in_beat, load_beat, comp_beat, res_wait, res_err, load_res;

    // beat qualifiers
    assign in_beat = i_valid && o_ready;
    assign load_beat = in_beat && ((i_func == c2d_pkg::FUNC_LOAD_ACT)
        || (i_func == c2d_pkg::FUNC_LOAD_WGT) || (i_func == c2d_pkg::FUNC_LOAD_OUT));
    assign comp_beat = in_beat && (i_func == c2d_pkg::FUNC_COMPUTE);
    assign res_wait = o_valid && !i_ready;
    assign res_err = o_valid && o_range_error;
    assign load_res = o_valid && (o_read_value == 32'd0) && !o_range_error;

    // a held result stays put
    `C2D_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, res_wait, o_valid && $stable(o_read_value))
    // a load beat gives a zero result next cycle
    `C2D_ASSERT_NEXT(a_load_res, i_clk, i_rst_n, load_beat, load_res)
    // a compute beat makes the block busy next cycle
    `C2D_ASSERT_NEXT(a_comp_busy, i_clk, i_rst_n, comp_beat, !o_ready)
    // range error shows only with a zero value
    `C2D_ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, res_err, o_read_value == 32'd0)
endmodule

bind conv2d_forward_accumulate c2d_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .i_func(i_func), .o_valid(o_valid), .i_ready(i_ready),
    .o_read_value(o_read_value), .o_range_error(o_range_error)
);

/* sim/conv2d_forward_accumulate_test.sv */
// self-checking testbench for the fixed point strided convolution block
// depends on c2d_pkg and conv2d_forward_accumulate; predicts each result beat in a scoreboard
module conv2d_forward_accumulate_test;
    localparam int MaxInCh = c2d_pkg::MaxInCh;
    localparam int MaxOutCh = c2d_pkg::MaxOutCh;
    localparam int MaxInDim = c2d_pkg::MaxInDim;
    localparam int MaxOutDim = c2d_pkg::MaxOutDim;
    localparam int MaxKernel = c2d_pkg::MaxKernel;
    localparam logic [2:0] FUNC_LOAD_ACT = c2d_pkg::FUNC_LOAD_ACT;
    localparam logic [2:0] FUNC_LOAD_WGT = c2d_pkg::FUNC_LOAD_WGT;
    localparam logic [2:0] FUNC_LOAD_OUT = c2d_pkg::FUNC_LOAD_OUT;
    localparam logic [2:0] FUNC_COMPUTE = c2d_pkg::FUNC_COMPUTE;
    localparam logic [2:0] FUNC_READ = c2d_pkg::FUNC_READ;
    localparam logic [2:0] REG_IN_CH = c2d_pkg::REG_IN_CH;
    localparam logic [2:0] REG_OUT_CH = c2d_pkg::REG_OUT_CH;
    localparam logic [2:0] REG_OUT_ROWS = c2d_pkg::REG_OUT_ROWS;
    localparam logic [2:0] REG_OUT_COLS = c2d_pkg::REG_OUT_COLS;
    localparam logic [2:0] REG_KER_ROWS = c2d_pkg::REG_KER_ROWS;
    localparam logic [2:0] REG_KER_COLS = c2d_pkg::REG_KER_COLS;
    localparam logic [2:0] REG_STR_ROWS = c2d_pkg::REG_STR_ROWS;
    localparam logic [2:0] REG_STR_COLS = c2d_pkg::REG_STR_COLS;

    typedef struct {
        logic signed [31:0] read_value;
        logic               done_res;
        logic               range_error;
    } t_beat;

    // convolution predictor and store of expected result beats
    class conv_scoreboard;
        logic signed [15:0] act_mem[MaxInCh*MaxInDim*MaxInDim];
        bit                 act_set[MaxInCh*MaxInDim*MaxInDim];
        logic signed [15:0] wgt_mem[MaxOutCh*MaxInCh*MaxKernel*MaxKernel];
        bit                 wgt_set[MaxOutCh*MaxInCh*MaxKernel*MaxKernel];
        logic signed [31:0] out_mem[MaxOutCh*MaxOutDim*MaxOutDim];
        bit                 out_set[MaxOutCh*MaxOutDim*MaxOutDim];
        int                 out_list[$];
        bit                 err_flag;
        int unsigned        regs[8];
        t_beat              want_q[$];
        int                 errors;

        function new();
            foreach (regs[i]) regs[i] = 1;
            err_flag = 0;
            errors = 0;
        endfunction

        // register value with the loop bound applied
        function int unsigned lim(int i);
            int unsigned top;
            case (i)
                REG_IN_CH:                top = MaxInCh;
                REG_OUT_CH:               top = MaxOutCh;
                REG_OUT_ROWS, REG_OUT_COLS: top = MaxOutDim;
                REG_KER_ROWS, REG_KER_COLS: top = MaxKernel;
                default:                  top = 1 << 30;
            endcase
            return regs[i] > top ? top : regs[i];
        endfunction

        function void set_reg(int i, int unsigned v);
            int unsigned mask;
            mask = (i < 2) ? 31 : (i < 4) ? 63 : 7;
            regs[i] = v & mask;
        endfunction

        function void mac_pass();
            int unsigned nic, noc, nr, nc, kr, kc, sr, sc, ir, ic, oa;
            longint sum;
            logic signed [15:0] a;
            nic = lim(REG_IN_CH);  noc = lim(REG_OUT_CH);
            nr = lim(REG_OUT_ROWS); nc = lim(REG_OUT_COLS);
            kr = lim(REG_KER_ROWS); kc = lim(REG_KER_COLS);
            sr = regs[REG_STR_ROWS]; sc = regs[REG_STR_COLS];
            err_flag = 0;
            for (int o = 0; o < noc; o++)
                for (int y = 0; y < nr; y++)
                    for (int x = 0; x < nc; x++) begin
                        oa = (o * MaxOutDim + y) * MaxOutDim + x;
                        sum = longint'(out_mem[oa]);
                        for (int c = 0; c < nic; c++)
                            for (int ky = 0; ky < kr; ky++)
                                for (int kx = 0; kx < kc; kx++) begin
                                    ir = y * sr + ky;
                                    ic = x * sc + kx;
                                    if (ir >= MaxInDim || ic >= MaxInDim) begin
                                        err_flag = 1;
                                        a = 0;
                                    end else begin
                                        a = act_mem[(c * MaxInDim + ir) * MaxInDim + ic];
                                    end
                                    sum += longint'(int'(wgt_mem[((o * MaxInCh + c) * MaxKernel
                                        + ky) * MaxKernel + kx]) * int'(a));
                                end
                        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
                        if (sum < -64'sd2147483648) sum = -64'sd2147483648;
                        out_mem[oa] = sum[31:0];
                    end
        endfunction

        // accepted command beat: update state and queue its result
        function void note_input(logic [2:0] fn, int oc, int ic, int row, int col,
                                 logic signed [15:0] smp, logic signed [31:0] accv);
            t_beat b;
            int idx;
            b.read_value = 0;
            b.done_res = 1;
            b.range_error = 0;
            case (fn)
                FUNC_LOAD_ACT: begin
                    idx = (ic * MaxInDim + row) * MaxInDim + col;
                    act_mem[idx] = smp;
                    act_set[idx] = 1;
                end
                FUNC_LOAD_WGT: begin
                    if (row < MaxKernel && col < MaxKernel) begin
                        idx = ((oc * MaxInCh + ic) * MaxKernel + row) * MaxKernel + col;
                        wgt_mem[idx] = smp;
                        wgt_set[idx] = 1;
                    end
                end
                FUNC_LOAD_OUT: begin
                    idx = (oc * MaxOutDim + row) * MaxOutDim + col;
                    out_mem[idx] = accv;
                    if (!out_set[idx]) out_list.push_back(idx);
                    out_set[idx] = 1;
                end
                FUNC_COMPUTE: begin
                    mac_pass();
                    b.range_error = err_flag;
                end
                FUNC_READ: b.read_value = out_mem[(oc * MaxOutDim + row) * MaxOutDim + col];
                default: ;
            endcase
            want_q.push_back(b);
        endfunction

        function void check_result(logic signed [31:0] rv, logic dn, logic re);
            t_beat b;
            if (want_q.size() == 0) begin
                $display("%0t: result beat with nothing expected: %0d %0b %0b",
                         $time, rv, dn, re);
                errors++;
                return;
            end
            b = want_q.pop_front();
            if (rv !== b.read_value) begin
                $display("%0t: read_value expected %0d actual %0d", $time, b.read_value, rv);
                errors++;
            end
            if (dn !== b.done_res) begin
                $display("%0t: done_res expected %0b actual %0b", $time, b.done_res, dn);
                errors++;
            end
            if (re !== b.range_error) begin
                $display("%0t: range_error expected %0b actual %0b", $time, b.range_error, re);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk, i_rst_n;
    logic               i_valid, o_ready, o_valid, i_ready;
    logic [2:0]         i_func;
    logic [3:0]         i_out_chan, i_in_chan;
    logic [4:0]         i_row_index, i_col_index;
    logic signed [15:0] i_sample;
    logic signed [31:0] i_acc_value;
    logic signed [31:0] o_read_value;
    logic               o_done_res, o_range_error;
    logic               i_cfg_valid, o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [5:0]         i_cfg_data;

    conv_scoreboard sb = new();
    int  beats_in = 0;
    bit  quiet = 0;

    conv2d_forward_accumulate i_dut (.*);

    // clock
    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    // run limit
    initial begin
        #20000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // result side backpressure
    always @(negedge i_clk) begin
        i_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 22);
    end

    // result beat monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_read_value, o_done_res, o_range_error);
    end

    // one command beat, with i_valid held low at random ahead of it
    task automatic send_cmd(logic [2:0] fn, int oc, int ic, int row, int col,
                            logic [15:0] smp, logic [31:0] accv);
        @(negedge i_clk);
        if (!quiet && $urandom_range(99) < 28) begin
            i_valid = 0;
            @(negedge i_clk);
        end
        i_valid = 1;
        i_func = fn;
        i_out_chan = oc;
        i_in_chan = ic;
        i_row_index = row;
        i_col_index = col;
        i_sample = smp;
        i_acc_value = accv;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(fn, oc, ic, row, col, smp, accv);
        beats_in++;
        quiet = (beats_in >= 700 && beats_in < 1000);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid = 0;
        while (sb.want_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [5:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1;
        i_cfg_index = idx;
        i_cfg_data = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid = 0;
    endtask

    task automatic set_all(int unsigned v[8]);
        wait_idle();
        for (int i = 0; i < 8; i++) write_reg(i[2:0], v[i][5:0]);
    endtask

    // load every store entry the next compute reads that holds no value yet
    task automatic fill_footprint();
        int unsigned nic, noc, nr, nc, kr, kc, ir, ic;
        nic = sb.lim(REG_IN_CH);  noc = sb.lim(REG_OUT_CH);
        nr = sb.lim(REG_OUT_ROWS); nc = sb.lim(REG_OUT_COLS);
        kr = sb.lim(REG_KER_ROWS); kc = sb.lim(REG_KER_COLS);
        if (noc == 0 || nr == 0 || nc == 0) return;
        for (int o = 0; o < noc; o++)
            for (int y = 0; y < nr; y++)
                for (int x = 0; x < nc; x++)
                    if (!sb.out_set[(o * MaxOutDim + y) * MaxOutDim + x])
                        send_cmd(FUNC_LOAD_OUT, o, 0, y, x, 0, $urandom());
        for (int o = 0; o < noc; o++)
            for (int c = 0; c < nic; c++)
                for (int ky = 0; ky < kr; ky++)
                    for (int kx = 0; kx < kc; kx++)
                        if (!sb.wgt_set[((o * MaxInCh + c) * MaxKernel + ky) * MaxKernel + kx])
                            send_cmd(FUNC_LOAD_WGT, o, c, ky, kx, $urandom(), 0);
        for (int c = 0; c < nic; c++)
            for (int y = 0; y < nr; y++)
                for (int x = 0; x < nc; x++)
                    for (int ky = 0; ky < kr; ky++)
                        for (int kx = 0; kx < kc; kx++) begin
                            ir = y * sb.regs[REG_STR_ROWS] + ky;
                            ic = x * sb.regs[REG_STR_COLS] + kx;
                            if (ir < MaxInDim && ic < MaxInDim
                                && !sb.act_set[(c * MaxInDim + ir) * MaxInDim + ic])
                                send_cmd(FUNC_LOAD_ACT, 0, c, ir, ic, $urandom(), 0);
                        end
    endtask

    task automatic read_some(int n);
        int idx;
        repeat (n) begin
            idx = sb.out_list[$urandom_range(sb.out_list.size() - 1)];
            send_cmd(FUNC_READ, idx / (MaxOutDim * MaxOutDim), $urandom(),
                     (idx / MaxOutDim) % MaxOutDim, idx % MaxOutDim, $urandom(), $urandom());
        end
    endtask

    // one random command, mostly aimed at the current footprint
    task automatic random_cmd();
        int unsigned pick, near, oc, ic, row, col;
        pick = $urandom_range(99);
        near = $urandom_range(99) < 70;
        oc = near ? $urandom_range(sb.regs[REG_OUT_CH] > 0 ? 3 : 0) : $urandom_range(15);
        ic = near ? $urandom_range(3) : $urandom_range(15);
        row = near ? $urandom_range(7) : $urandom_range(31);
        col = near ? $urandom_range(7) : $urandom_range(31);
        if (pick < 30) send_cmd(FUNC_LOAD_ACT, $urandom(), ic, row, col, $urandom(), $urandom());
        else if (pick < 50) send_cmd(FUNC_LOAD_WGT, oc, ic, near ? row % 4 : row,
                                     near ? col % 4 : col, $urandom(), $urandom());
        else if (pick < 65) send_cmd(FUNC_LOAD_OUT, oc, $urandom(), row, col,
                                     $urandom(), $urandom());
        else if (pick < 75) begin
            fill_footprint();
            send_cmd(FUNC_COMPUTE, $urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom());
        end else if (pick < 95) read_some(1);
        else send_cmd($urandom_range(5, 7), $urandom(), $urandom(), $urandom(), $urandom(),
                      $urandom(), $urandom());
    endtask

    // stimulus
    initial begin
        int unsigned cfg[8];
        int unsigned phases[8][8] = '{
            '{2, 2, 3, 3, 2, 2, 1, 1},
            '{1, 1, 32, 1, 1, 1, 1, 1},
            '{1, 1, 1, 32, 4, 4, 1, 1},
            '{31, 2, 1, 1, 1, 1, 1, 1},
            '{1, 1, 63, 0, 7, 7, 3, 3},
            '{1, 1, 2, 2, 7, 7, 0, 0},
            '{1, 1, 9, 1, 1, 1, 4, 1},
            '{0, 1, 2, 2, 2, 2, 2, 2}
        };
        i_rst_n = 0;
        i_valid = 0;
        i_func = FUNC_LOAD_ACT;
        i_out_chan = 0;
        i_in_chan = 0;
        i_row_index = 0;
        i_col_index = 0;
        i_sample = 0;
        i_acc_value = 0;
        i_cfg_valid = 0;
        i_cfg_index = REG_IN_CH;
        i_cfg_data = 0;
        i_ready = 1;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // reset config: saturation both ways, sample extremes, odd funcs
        send_cmd(FUNC_LOAD_ACT, 0, 0, 0, 0, 16'h8000, 0);
        send_cmd(FUNC_LOAD_WGT, 0, 0, 0, 0, 16'h8000, 0);
        send_cmd(FUNC_LOAD_OUT, 0, 0, 0, 0, 0, 32'h7fff0000);
        send_cmd(FUNC_COMPUTE, 0, 0, 0, 0, 0, 0);
        send_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0);
        send_cmd(FUNC_LOAD_WGT, 0, 0, 0, 0, 16'h7fff, 0);
        send_cmd(FUNC_LOAD_OUT, 0, 0, 0, 0, 0, 32'h80000000);
        send_cmd(FUNC_COMPUTE, 0, 0, 0, 0, 0, 0);
        send_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0);
        send_cmd(FUNC_LOAD_WGT, 15, 15, 7, 31, 16'h7fff, 0);
        send_cmd(FUNC_LOAD_OUT, 15, 0, 31, 31, 0, 32'h7fffffff);
        send_cmd(FUNC_READ, 15, 15, 31, 31, 16'hffff, 32'hffffffff);
        send_cmd(3'd5, 15, 15, 31, 31, 16'hffff, 32'hffffffff);
        send_cmd(3'd6, 0, 0, 0, 0, 0, 0);
        send_cmd(3'd7, 0, 0, 0, 0, 0, 0);

        // directed configurations: bounds, zeros, over-range, window overrun
        foreach (phases[p]) begin
            foreach (cfg[i]) cfg[i] = phases[p][i];
            set_all(cfg);
            fill_footprint();
            send_cmd(FUNC_COMPUTE, 0, 0, 0, 0, 0, 0);
            read_some(3);
        end

        // random small configurations with mixed traffic
        while (beats_in < 1950) begin
            cfg[0] = $urandom_range(1, 3);
            cfg[1] = $urandom_range(1, 3);
            cfg[2] = $urandom_range(1, 4);
            cfg[3] = $urandom_range(1, 4);
            cfg[4] = $urandom_range(1, 3);
            cfg[5] = $urandom_range(1, 3);
            cfg[6] = $urandom_range(0, 3);
            cfg[7] = $urandom_range(0, 3);
            set_all(cfg);
            fill_footprint();
            repeat (120) random_cmd();
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.want_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
